/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/tbww_pkg.sv */
package tbww_pkg;

   // operation codes
   localparam logic [1:0] OP_SET  = 2'd0;
   localparam logic [1:0] OP_LOAD = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_NOP  = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_LAYOUT_MODE      = 2'd0;
   localparam logic [1:0] CSR_FIRST_WORD       = 2'd1;
   localparam logic [1:0] CSR_WORDS_PER_ENTITY = 2'd2;

   localparam logic [6:0] WPE_RESET = 7'd16;

   // field widths
   localparam int ENT_W         = 16;
   localparam int WORD_W        = 32;
   localparam int HALF_W        = 16;
   localparam int SC_W          = 6;
   localparam int RADDR_W       = 12;
   localparam int WORD_ADDR_W   = 12;
   localparam int REF_ENTRY_W   = 17;
   localparam int WPE_W         = 7;
   localparam int PROD_W        = ENT_W + WPE_W;
   localparam int SPAN_W        = PROD_W + 1;
   localparam int CALC_W        = SPAN_W + 1;

   // binary32 to binary16 conversion constants
   localparam int F32_BIAS  = 127;
   localparam int F16_BIAS  = 15;
   localparam int SUB_SHIFT = 14;
   localparam logic [7:0] EXP_REBIAS   = 8'(F32_BIAS - F16_BIAS);
   localparam logic [7:0] EXP_OVERFLOW = 8'(F32_BIAS - F16_BIAS + 31);
   localparam logic [7:0] EXP_TINY     = 8'(F32_BIAS - F16_BIAS - 10);
   localparam logic [7:0] EXP_SHIFT0   = 8'(F32_BIAS - F16_BIAS + SUB_SHIFT);
   localparam logic [14:0] HALF_INF    = 15'h7c00;
   localparam logic [14:0] HALF_QNAN   = 15'h7e00;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic calc;
      logic read;
      logic finish;
   } tbww_cmd_type;

   typedef struct packed {
      logic clear_last;
   } tbww_status_type;

endpackage

/* rtl/tbww_ctrl.sv */
module tbww_ctrl
   import tbww_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  tbww_status_type status,
   output tbww_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_ADDR  = 5'b00100,
      ST_READ  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_ADDR;
            end
         end
         ST_ADDR: begin
            cmd.calc = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold the result until the output register is free
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      if (cmd.finish) rsp_valid_in = 1'b1;
      else            rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/tbww_datapath.sv */
module tbww_datapath
   import tbww_pkg::*;
#(
   parameter int STORE_WORDS = 4096,
   parameter int REF_ENTRIES = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tbww_cmd_type           cmd,
   output tbww_status_type        status,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_write_data,
   input  logic [1:0]             req_op,
   input  logic [ENT_W-1:0]       req_entity_index,
   input  logic [WORD_W-1:0]      req_value_bits,
   input  logic [SC_W-1:0]        req_scalar_pos,
   input  logic                   req_ref_format,
   input  logic [15:0]            req_ref_word_offset,
   input  logic [RADDR_W-1:0]     req_read_address,
   output logic [WORD_ADDR_W-1:0] rsp_word_address,
   output logic [WORD_W-1:0]      rsp_word_data,
   output logic                   rsp_out_of_range
);

   localparam int AW = $clog2(STORE_WORDS);
   localparam int RW = (REF_ENTRIES > 1) ? $clog2(REF_ENTRIES) : 1;
   localparam logic [SPAN_W-1:0]      STORE_LIMIT = SPAN_W'(STORE_WORDS);
   localparam logic [REF_ENTRY_W-1:0] REF_LIMIT   = REF_ENTRY_W'(REF_ENTRIES);
   localparam logic [AW-1:0]          CLR_LAST    = AW'(STORE_WORDS - 1);

   function automatic logic [HALF_W-1:0] to_half(input logic [WORD_W-1:0] bits);
      logic        sgn;
      logic [7:0]  e;
      logic [22:0] mant;
      logic [23:0] m;
      logic [4:0]  sh;
      logic [23:0] shifted;
      logic [14:0] mag;
      sgn     = bits[31];
      e       = bits[30:23];
      mant    = bits[22:0];
      m       = {1'b1, mant};
      sh      = 5'(EXP_SHIFT0 - e);
      shifted = '0;
      mag     = '0;
      if (e == 8'hff) begin
         mag = (mant == '0) ? HALF_INF : HALF_QNAN;
      end else if (e >= EXP_OVERFLOW) begin
         mag = HALF_INF;
      end else if (e <= EXP_REBIAS) begin
         if (e >= EXP_TINY) begin
            // keep the round bit in the lsb
            shifted = m >> (sh - 5'd1);
            mag     = 15'(shifted >> 1) + 15'(shifted[0]);
         end
      end else begin
         mag = {5'(e - EXP_REBIAS), mant[22:13]} + 15'(mant[12]);
      end
      return {sgn, mag};
   endfunction

   // configuration
   logic [1:0]       layout_mode_ff;
   logic [15:0]      first_word_ff;
   logic [WPE_W-1:0] words_per_entity_ff;

   // captured item
   logic [1:0]             op_ff;
   logic [SC_W-1:0]        sc_ff;
   logic [WORD_W-1:0]      value_ff;
   logic [HALF_W-1:0]      half_ff, half_in;
   logic [RADDR_W-1:0]     raddr_ff;
   logic [REF_ENTRY_W-1:0] entry_ff, entry_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic                   ent_bad_ff, ent_bad_in;
   logic [REF_ENTRY_W-1:0] ref_rd_ff;

   // address stage
   logic                   mixed, half_fmt;
   logic [SC_W-1:0]        sc_term;
   logic [SPAN_W-1:0]      base;
   logic [CALC_W-1:0]      set_sum, calc;
   logic                   range_bad;
   logic [AW-1:0]          addr_ff;
   logic                   oor_ff, oor_in;
   logic [WORD_ADDR_W-1:0] wa_ff, wa_in;
   logic                   half_fmt_ff;

   // store access
   logic [WORD_W-1:0]      rd_data_ff;
   logic [WORD_W-1:0]      merged, set_word, data_in;
   logic                   store_wr;
   logic [AW-1:0]          clr_ff;

   logic [WORD_ADDR_W-1:0] rsp_word_address_ff;
   logic [WORD_W-1:0]      rsp_word_data_ff;
   logic                   rsp_out_of_range_ff;

   logic [WORD_W-1:0]      store_mem [STORE_WORDS];
   logic [REF_ENTRY_W-1:0] ref_mem   [REF_ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_mode_ff      <= '0;
         first_word_ff       <= '0;
         words_per_entity_ff <= WPE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LAYOUT_MODE:      layout_mode_ff      <= csr_write_data[1:0];
            CSR_FIRST_WORD:       first_word_ff       <= csr_write_data;
            CSR_WORDS_PER_ENTITY: words_per_entity_ff <= csr_write_data[WPE_W-1:0];
            default: ;
         endcase
      end
   end

   assign half_in    = to_half(req_value_bits);
   assign prod_in    = PROD_W'(req_entity_index) * PROD_W'(words_per_entity_ff);
   assign ent_bad_in = REF_ENTRY_W'(req_entity_index) >= REF_LIMIT;
   assign entry_in   = {req_ref_format, req_ref_word_offset};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_op;
         sc_ff      <= req_scalar_pos;
         value_ff   <= req_value_bits;
         half_ff    <= half_in;
         raddr_ff   <= req_read_address;
         entry_ff   <= entry_in;
         prod_ff    <= prod_in;
         ent_bad_ff <= ent_bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         if (req_op == OP_LOAD && !ent_bad_in) begin
            ref_mem[req_entity_index[RW-1:0]] <= entry_in;
         end
         ref_rd_ff <= ref_mem[req_entity_index[RW-1:0]];
      end
   end

   always_comb begin
      mixed    = layout_mode_ff[1];
      half_fmt = mixed ? ref_rd_ff[REF_ENTRY_W-1] : layout_mode_ff[0];
      sc_term  = half_fmt ? {1'b0, sc_ff[SC_W-1:1]} : sc_ff;
      base     = mixed ? SPAN_W'(ref_rd_ff[15:0]) : SPAN_W'(prod_ff);
      set_sum  = {1'b0, base} + CALC_W'(sc_term) - CALC_W'(first_word_ff);
      case (op_ff)
         OP_SET:  calc = set_sum;
         OP_READ: calc = CALC_W'(raddr_ff);
         default: calc = '0;
      endcase
      range_bad = calc[CALC_W-1] || (calc[SPAN_W-1:0] >= STORE_LIMIT);
      case (op_ff)
         OP_SET:  oor_in = (mixed && ent_bad_ff) || range_bad;
         OP_READ: oor_in = range_bad;
         OP_LOAD: oor_in = ent_bad_ff;
         default: oor_in = 1'b0;
      endcase
      if ((op_ff == OP_SET || op_ff == OP_READ) && !oor_in) wa_in = calc[WORD_ADDR_W-1:0];
      else                                                   wa_in = '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         addr_ff     <= calc[AW-1:0];
         oor_ff      <= oor_in;
         wa_ff       <= wa_in;
         half_fmt_ff <= half_fmt;
      end
   end

   always_comb begin
      merged   = sc_ff[0] ? {half_ff, rd_data_ff[15:0]} : {rd_data_ff[31:16], half_ff};
      set_word = half_fmt_ff ? merged : value_ff;
      case (op_ff)
         OP_SET:  data_in = set_word;
         OP_LOAD: data_in = WORD_W'(entry_ff);
         OP_READ: data_in = rd_data_ff;
         default: data_in = '0;
      endcase
      if (oor_ff) data_in = '0;
      store_wr = cmd.finish && op_ff == OP_SET && !oor_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         store_mem[clr_ff] <= '0;
      end else if (store_wr) begin
         store_mem[addr_ff] <= set_word;
      end
      if (cmd.read) begin
         rd_data_ff <= store_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   assign status.clear_last = (clr_ff == CLR_LAST);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_word_address_ff <= wa_ff;
         rsp_word_data_ff    <= data_in;
         rsp_out_of_range_ff <= oor_ff;
      end
   end

   assign rsp_word_address = rsp_word_address_ff;
   assign rsp_word_data    = rsp_word_data_ff;
   assign rsp_out_of_range = rsp_out_of_range_ff;

endmodule

/* rtl/transform_blob_word_writer.sv */
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  op, entity, value, scalar pos, ref entry, read addr
// rsp_      out        rsp_valid/rsp_stall  word_address, word_data, out_of_range
// csr_      in         csr_write_enable     csr_index, csr_write_data
//
// An item is taken in idle and walks four steps: capture (with the entity-times-stride
// multiply and reference table read), address and range check, store word read, merge
// and write. Its result is registered at the end of the merge and write step, and the
// input reopens with it, so a new item is taken only once the last one is through.
// The single store port and this sequence keep one item in flight.
// After reset a clearing pass zeroes the store, with req_stall high.
// A result waiting under rsp_stall does not block the next item; that item holds in
// its last step until the output register frees up.
module transform_blob_word_writer
   import tbww_pkg::*;
#(
   parameter int STORE_WORDS = 4096,
   parameter int REF_ENTRIES = 1024
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_write_data,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic [ENT_W-1:0]       req_entity_index,
   input  logic [WORD_W-1:0]      req_value_bits,
   input  logic [SC_W-1:0]        req_scalar_pos,
   input  logic                   req_ref_format,
   input  logic [15:0]            req_ref_word_offset,
   input  logic [RADDR_W-1:0]     req_read_address,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WORD_ADDR_W-1:0] rsp_word_address,
   output logic [WORD_W-1:0]      rsp_word_data,
   output logic                   rsp_out_of_range
);

   tbww_cmd_type    cmd;
   tbww_status_type status;

   // sequencer: clearing pass, item steps, output valid
   tbww_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, address math, half conversion, reference table and word store
   tbww_datapath #(
      .STORE_WORDS (STORE_WORDS),
      .REF_ENTRIES (REF_ENTRIES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_op              (req_op),
      .req_entity_index    (req_entity_index),
      .req_value_bits      (req_value_bits),
      .req_scalar_pos      (req_scalar_pos),
      .req_ref_format      (req_ref_format),
      .req_ref_word_offset (req_ref_word_offset),
      .req_read_address    (req_read_address),
      .rsp_word_address    (rsp_word_address),
      .rsp_word_data       (rsp_word_data),
      .rsp_out_of_range    (rsp_out_of_range)
   );

endmodule

/* rtl/tbww_checker.sv */
`include "assert_macros.svh"

module tbww_checker
   import tbww_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [WORD_ADDR_W-1:0] rsp_word_address,
   input logic [WORD_W-1:0]      rsp_word_data,
   input logic                   rsp_out_of_range
);

   // a stalled result stays offered
   `ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "rsp_valid dropped under stall")

   // a stalled result keeps its payload
   `ASSERT_CLK(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_word_address) && $stable(rsp_word_data) && $stable(rsp_out_of_range), "rsp payload changed under stall")

   // the clearing pass blocks input right after reset
   `ASSERT_ALWAYS(a_clear_stall, $past(reset) |-> req_stall, "input open during store clear")

   // no result appears straight out of reset
   `ASSERT_ALWAYS(a_no_rsp_after_reset, $past(reset) |-> !rsp_valid, "result valid after reset")

   // one item in flight: input closes after an acceptance
   `ASSERT_CLK(a_one_item, req_valid && !req_stall |=> req_stall, "second item taken during work")

endmodule

bind transform_blob_word_writer tbww_checker u_checker (.*);
